// ===== design/i2cm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types and constants of the tick-timed I2C master.
// ----------------------------------------------------------------------------
package i2cm_pkg;

  localparam int COUNT_WIDTH_DEFAULT = 8;
  localparam logic [7:0] HALF_PERIOD_RESET = 8'd5;

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic       mode;
    logic [6:0] address;
    logic       read_not_write;
    logic [7:0] byte_count;
    logic [7:0] write_data;
    logic       sda_in;
  } i2cm_in_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic [7:0] byte_index;
    logic [7:0] read_data;
    logic       read_valid;
    logic       busy_res;
    logic       done_res;
    logic       nack_error;
  } i2cm_out_t;

  typedef enum logic {
    OP_TICK  = 1'b0,
    OP_START = 1'b1
  } i2cm_op_kind_t;

  typedef struct packed {
    i2cm_op_kind_t kind;
    logic [6:0]    address;
    logic          read_not_write;
    logic [7:0]    byte_count;
    logic [7:0]    write_data;
    logic          sda_in;
  } i2cm_op_t;

  // handshake from the front queue to the engine
  typedef struct packed {
    logic valid;
    logic take;
  } i2cm_link_t;

endpackage : i2cm_pkg
`default_nettype wire

// ===== design/i2cm_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// i2cm_front
// Accepts input transactions, classifies them as tick or start, and holds
// them in a short queue in front of the bit engine.
// ----------------------------------------------------------------------------
module i2cm_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  i2cm_pkg::i2cm_in_t request,
  output i2cm_pkg::i2cm_op_t op,
  output logic             op_valid,
  input  logic             op_take
);
  import i2cm_pkg::*;

  i2cm_op_t             mem [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr;
  logic [Q_PTR_W-1:0]   rd_ptr;
  logic [Q_CNT_W-1:0]   count;
  logic                 push_fire;
  logic                 take_fire;
  i2cm_op_t             classified;

  assign full      = (count == Q_CNT_W'(Q_DEPTH));
  assign push_fire = push && !full;
  assign take_fire = op_take && (count != '0);
  assign op_valid  = (count != '0);
  assign op        = mem[rd_ptr];

  always_comb begin
    classified.kind           = request.mode ? OP_START : OP_TICK;
    classified.address        = request.address;
    classified.read_not_write = request.read_not_write;
    classified.byte_count     = request.byte_count;
    classified.write_data     = request.write_data;
    classified.sda_in         = request.sda_in;
  end

  always_ff @(posedge clk) begin
    if (push_fire) begin
      mem[wr_ptr] <= classified;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_fire) begin
        wr_ptr <= Q_PTR_W'((32'(wr_ptr) + 1) % Q_DEPTH);
      end
      if (take_fire) begin
        rd_ptr <= Q_PTR_W'((32'(rd_ptr) + 1) % Q_DEPTH);
      end
      count <= count + Q_CNT_W'(push_fire) - Q_CNT_W'(take_fire);
    end
  end

endmodule : i2cm_front
`default_nettype wire

// ===== design/i2cm_engine.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// i2cm_engine
// Bit engine: one queued operation per cycle while the result queue is ready,
// advancing START, address, data, acknowledge and STOP, one result each.
// ----------------------------------------------------------------------------
module i2cm_engine #(
  parameter int COUNT_WIDTH = i2cm_pkg::COUNT_WIDTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [7:0]          half_period_ticks,
  input  i2cm_pkg::i2cm_op_t  op,
  input  logic                op_valid,
  output logic                op_take,
  input  logic                res_ready,
  output logic                res_valid,
  output i2cm_pkg::i2cm_out_t res
);
  import i2cm_pkg::*;

  localparam int CMP_W = ((COUNT_WIDTH > 8) ? COUNT_WIDTH : 8) + 1;

  typedef enum logic [14:0] {
    PH_IDLE = 15'h0001,
    PH_S1   = 15'h0002,
    PH_S2   = 15'h0004,
    PH_S3   = 15'h0008,
    PH_TXH  = 15'h0010,
    PH_TXL  = 15'h0020,
    PH_ACKH = 15'h0040,
    PH_ACKL = 15'h0080,
    PH_RXH  = 15'h0100,
    PH_RXL  = 15'h0200,
    PH_MAH  = 15'h0400,
    PH_MAL  = 15'h0800,
    PH_P1   = 15'h1000,
    PH_P2   = 15'h2000,
    PH_P3   = 15'h4000
  } phase_t;

  phase_t                 phase, phase_next;
  logic [7:0]             hp_counter, hp_counter_next;
  logic [3:0]             bit_counter, bit_counter_next;
  logic [COUNT_WIDTH-1:0] byte_counter, byte_counter_next;
  logic [7:0]             shift_reg, shift_reg_next;
  logic [6:0]             cmd_address, cmd_address_next;
  logic                   cmd_read, cmd_read_next;
  logic [7:0]             cmd_count, cmd_count_next;
  logic                   error_flag, error_flag_next;
  logic                   scl, scl_next;
  logic                   sda, sda_next;
  logic                   addr_stage, addr_stage_next;

  logic                   fire;
  logic [7:0]             hp_eff;
  logic [7:0]             hp_inc;
  logic                   hp_reached;
  logic [3:0]             bit_inc;
  logic [COUNT_WIDTH-1:0] byte_inc;
  logic [CMP_W-1:0]       byte_ext;
  logic [CMP_W-1:0]       byte_inc_ext;
  logic [CMP_W-1:0]       count_ext;
  logic [CMP_W-1:0]       byte_out_ext;
  logic                   rvalid;
  logic [7:0]             rdata;
  logic                   done;

  assign fire      = op_valid && res_ready;
  assign op_take   = fire;
  assign res_valid = fire;

  assign hp_eff       = (half_period_ticks == 8'd0) ? 8'd1 : half_period_ticks;
  assign hp_inc       = hp_counter + 8'd1;
  assign hp_reached   = (hp_inc >= hp_eff);
  assign bit_inc      = bit_counter + 4'd1;
  assign byte_inc     = byte_counter + COUNT_WIDTH'(1);
  assign byte_ext     = CMP_W'(byte_counter);
  assign byte_inc_ext = CMP_W'(byte_inc);
  assign count_ext    = CMP_W'(cmd_count);

  always_comb begin
    phase_next        = phase;
    hp_counter_next   = hp_counter;
    bit_counter_next  = bit_counter;
    byte_counter_next = byte_counter;
    shift_reg_next    = shift_reg;
    cmd_address_next  = cmd_address;
    cmd_read_next     = cmd_read;
    cmd_count_next    = cmd_count;
    error_flag_next   = error_flag;
    scl_next          = scl;
    sda_next          = sda;
    addr_stage_next   = addr_stage;
    rvalid            = 1'b0;
    rdata             = 8'd0;
    done              = 1'b0;
    if (phase == PH_IDLE) begin
      if (op.kind == OP_START) begin
        cmd_address_next  = op.address;
        cmd_read_next     = op.read_not_write;
        cmd_count_next    = op.byte_count;
        error_flag_next   = 1'b0;
        byte_counter_next = '0;
        bit_counter_next  = 4'd0;
        shift_reg_next    = 8'd0;
        hp_counter_next   = 8'd0;
        addr_stage_next   = 1'b1;
        phase_next        = PH_S1;
        scl_next          = 1'b1;
        sda_next          = 1'b1;
      end
    end else if (op.kind == OP_TICK) begin
      hp_counter_next = hp_reached ? 8'd0 : hp_inc;
      if (hp_reached) begin
        unique case (phase)
          PH_S1: begin
            phase_next = PH_S2;
            scl_next   = 1'b1;
            sda_next   = 1'b0;
          end
          PH_S2: begin
            phase_next = PH_S3;
            scl_next   = 1'b0;
            sda_next   = 1'b0;
          end
          PH_S3: begin
            shift_reg_next   = {cmd_address, cmd_read};
            bit_counter_next = 4'd0;
            phase_next       = PH_TXH;
            scl_next         = 1'b1;
            sda_next         = cmd_address[6];
          end
          PH_TXH: begin
            phase_next = PH_TXL;
            scl_next   = 1'b0;
          end
          PH_TXL: begin
            bit_counter_next = bit_inc;
            if (!bit_inc[3]) begin
              shift_reg_next = {shift_reg[6:0], 1'b0};
              phase_next     = PH_TXH;
              scl_next       = 1'b1;
              sda_next       = shift_reg[6];
            end else begin
              phase_next = PH_ACKH;
              scl_next   = 1'b1;
              sda_next   = 1'b1;
            end
          end
          PH_ACKH: begin
            if (op.sda_in) begin
              error_flag_next = 1'b1;
            end else if (addr_stage) begin
              addr_stage_next = 1'b0;
            end else begin
              byte_counter_next = byte_inc;
            end
            phase_next = PH_ACKL;
            scl_next   = 1'b0;
            sda_next   = 1'b1;
          end
          PH_ACKL: begin
            if (error_flag || (byte_ext >= count_ext)) begin
              phase_next = PH_P1;
              scl_next   = 1'b0;
              sda_next   = 1'b0;
            end else if (cmd_read) begin
              shift_reg_next   = 8'd0;
              bit_counter_next = 4'd0;
              phase_next       = PH_RXH;
              scl_next         = 1'b1;
              sda_next         = 1'b1;
            end else begin
              shift_reg_next   = op.write_data;
              bit_counter_next = 4'd0;
              phase_next       = PH_TXH;
              scl_next         = 1'b1;
              sda_next         = op.write_data[7];
            end
          end
          PH_RXH: begin
            shift_reg_next = {shift_reg[6:0], op.sda_in};
            phase_next     = PH_RXL;
            scl_next       = 1'b0;
            sda_next       = 1'b1;
          end
          PH_RXL: begin
            bit_counter_next = bit_inc;
            if (!bit_inc[3]) begin
              phase_next = PH_RXH;
              scl_next   = 1'b1;
              sda_next   = 1'b1;
            end else begin
              rvalid     = 1'b1;
              rdata      = shift_reg;
              phase_next = PH_MAH;
              scl_next   = 1'b1;
              sda_next   = ((byte_ext + CMP_W'(1)) >= count_ext);
            end
          end
          PH_MAH: begin
            phase_next = PH_MAL;
            scl_next   = 1'b0;
            sda_next   = 1'b1;
          end
          PH_MAL: begin
            byte_counter_next = byte_inc;
            if (byte_inc_ext < count_ext) begin
              shift_reg_next   = 8'd0;
              bit_counter_next = 4'd0;
              phase_next       = PH_RXH;
              scl_next         = 1'b1;
              sda_next         = 1'b1;
            end else begin
              phase_next = PH_P1;
              scl_next   = 1'b0;
              sda_next   = 1'b0;
            end
          end
          PH_P1: begin
            phase_next = PH_P2;
            scl_next   = 1'b1;
            sda_next   = 1'b0;
          end
          PH_P2: begin
            phase_next = PH_P3;
            scl_next   = 1'b1;
            sda_next   = 1'b1;
          end
          PH_P3: begin
            done       = 1'b1;
            phase_next = PH_IDLE;
            scl_next   = 1'b1;
            sda_next   = 1'b1;
          end
          default: begin
            phase_next = PH_IDLE;
            scl_next   = 1'b1;
            sda_next   = 1'b1;
          end
        endcase
      end
    end
  end

  assign byte_out_ext = CMP_W'(byte_counter_next);

  always_comb begin
    res.scl_out    = scl_next;
    res.sda_out    = sda_next;
    res.byte_index = byte_out_ext[7:0];
    res.read_data  = rdata;
    res.read_valid = rvalid;
    res.busy_res   = (phase_next != PH_IDLE);
    res.done_res   = done;
    res.nack_error = error_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      hp_counter   <= 8'd0;
      bit_counter  <= 4'd0;
      byte_counter <= '0;
      shift_reg    <= 8'd0;
      cmd_address  <= 7'd0;
      cmd_read     <= 1'b0;
      cmd_count    <= 8'd0;
      error_flag   <= 1'b0;
      scl          <= 1'b1;
      sda          <= 1'b1;
      addr_stage   <= 1'b0;
    end else if (fire) begin
      phase        <= phase_next;
      hp_counter   <= hp_counter_next;
      bit_counter  <= bit_counter_next;
      byte_counter <= byte_counter_next;
      shift_reg    <= shift_reg_next;
      cmd_address  <= cmd_address_next;
      cmd_read     <= cmd_read_next;
      cmd_count    <= cmd_count_next;
      error_flag   <= error_flag_next;
      scl          <= scl_next;
      sda          <= sda_next;
      addr_stage   <= addr_stage_next;
    end
  end

endmodule : i2cm_engine
`default_nettype wire

// ===== design/i2cm_result_q.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// i2cm_result_q
// Result queue between the bit engine and the consumer.
// ----------------------------------------------------------------------------
module i2cm_result_q (
  input  logic                clk,
  input  logic                rst,
  input  logic                res_valid,
  input  i2cm_pkg::i2cm_out_t res,
  output logic                res_ready,
  output logic                empty,
  input  logic                pop,
  output i2cm_pkg::i2cm_out_t result
);
  import i2cm_pkg::*;

  i2cm_out_t          mem [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] count;
  logic               push_fire;
  logic               pop_fire;

  assign empty     = (count == '0);
  assign pop_fire  = pop && !empty;
  assign res_ready = (count != Q_CNT_W'(Q_DEPTH)) || pop_fire;
  assign push_fire = res_valid && res_ready;
  assign result    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push_fire) begin
      mem[wr_ptr] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_fire) begin
        wr_ptr <= Q_PTR_W'((32'(wr_ptr) + 1) % Q_DEPTH);
      end
      if (pop_fire) begin
        rd_ptr <= Q_PTR_W'((32'(rd_ptr) + 1) % Q_DEPTH);
      end
      count <= count + Q_CNT_W'(push_fire) - Q_CNT_W'(pop_fire);
    end
  end

endmodule : i2cm_result_q
`default_nettype wire

// ===== design/i2c_master_bit_engine.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// i2c_master_bit_engine
// Tick-timed I2C master: START, address, data bytes with acknowledge, STOP.
//
//   channel   signals                     handshake
//   input     push, full, request         accepted when push && !full
//   result    empty, pop, result          accepted when pop && !empty
//   config    cfg_wr_en, cfg_wr_data      written when cfg_wr_en
//
// one transaction in and one result out per cycle, sustained while results are
// popped; an accepted input is held in the front queue, then the bit engine
// writes its result into the result queue. the bit engine's combinational step
// sets the rate. reset empties both queues, idles the engine, half period =
// 5 ticks. a stalled result side fills the result queue, then the front queue;
// full rises with four transactions held.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine #(
  parameter int COUNT_WIDTH = i2cm_pkg::COUNT_WIDTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  i2cm_pkg::i2cm_in_t  request,
  output logic                empty,
  input  logic                pop,
  output i2cm_pkg::i2cm_out_t result,
  input  logic                cfg_wr_en,
  input  logic [7:0]          cfg_wr_data
);
  import i2cm_pkg::*;

  logic [7:0] half_period_ticks;
  i2cm_op_t   op;
  i2cm_link_t link;
  logic       op_take;
  logic       res_ready;
  logic       res_valid;
  i2cm_out_t  res;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_period_ticks <= HALF_PERIOD_RESET;
    end else if (cfg_wr_en) begin
      half_period_ticks <= cfg_wr_data;
    end
  end

  assign link.take = op_take;

  i2cm_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .request  (request),
    .op       (op),
    .op_valid (link.valid),
    .op_take  (link.take)
  );

  i2cm_engine #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_engine (
    .clk               (clk),
    .rst               (rst),
    .half_period_ticks (half_period_ticks),
    .op                (op),
    .op_valid          (link.valid),
    .op_take           (op_take),
    .res_ready         (res_ready),
    .res_valid         (res_valid),
    .res               (res)
  );

  i2cm_result_q u_result_q (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

endmodule : i2c_master_bit_engine
`default_nettype wire

// ===== test/tb_i2c_master_bit_engine.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tb_i2c_master_bit_engine
// Self-checking bench for the tick-timed I2C master. Start and tick
// transactions go through the input queue. A bit-level model of the engine
// predicts the result of each accepted transaction, and every popped result
// is compared with it field by field. Directed cases cover reset timing,
// reads, writes, NACK endings and half-period changes, and random transfers
// follow. Both queue sides idle at random, and the result side sometimes
// stalls for a long time.
// ----------------------------------------------------------------------------
module tb_i2c_master_bit_engine;
  import i2cm_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_ITEMS   = 150;
  localparam int MAX_REPORTS    = 10;
  localparam int RX_HOLD_CYCLES = 80;
  localparam int NACK_NEVER     = -1;
  localparam int NACK_RANDOM    = -2;

  typedef enum logic [14:0] {
    ST_IDLE      = 15'h0001,
    ST_START_A   = 15'h0002,
    ST_START_B   = 15'h0004,
    ST_START_C   = 15'h0008,
    ST_TX_HIGH   = 15'h0010,
    ST_TX_LOW    = 15'h0020,
    ST_ACK_HIGH  = 15'h0040,
    ST_ACK_LOW   = 15'h0080,
    ST_RX_HIGH   = 15'h0100,
    ST_RX_LOW    = 15'h0200,
    ST_MACK_HIGH = 15'h0400,
    ST_MACK_LOW  = 15'h0800,
    ST_STOP_A    = 15'h1000,
    ST_STOP_B    = 15'h2000,
    ST_STOP_C    = 15'h4000
  } bus_state_t;

  logic       clk;
  logic       rst;
  logic       push;
  logic       full;
  i2cm_in_t   request;
  logic       empty;
  logic       pop;
  i2cm_out_t  result;
  logic       cfg_wr_en;
  logic [7:0] cfg_wr_data;

  i2c_master_bit_engine i_dut (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .request    (request),
    .empty      (empty),
    .pop        (pop),
    .result     (result),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // engine model state
  bus_state_t bus_state;
  logic [7:0] half_ticks;
  logic [7:0] tick_cnt;
  logic [3:0] bit_cnt;
  logic [7:0] byte_cnt;
  logic [7:0] shreg;
  logic [6:0] cmd_addr;
  logic       cmd_rnw;
  logic [7:0] cmd_count;
  logic       nack_seen;
  logic       bus_scl;
  logic       bus_sda;
  logic       addr_phase;

  i2cm_out_t   expected_q[$];
  int          errors = 0;
  int          items_sent = 0;
  int          idle_cycles = 0;
  int          hold_requests = 0;
  int          nack_plan = NACK_NEVER;
  bit          steady_flow = 1'b0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic enter_state(input bus_state_t s, input logic scl, input logic sda);
    bus_state = s;
    bus_scl   = scl;
    bus_sda   = sda;
  endtask

  task automatic load_tx_byte(input logic [7:0] b);
    shreg   = b;
    bit_cnt = '0;
    enter_state(ST_TX_HIGH, 1'b1, b[7]);
  endtask

  task automatic load_rx_byte();
    shreg   = '0;
    bit_cnt = '0;
    enter_state(ST_RX_HIGH, 1'b1, 1'b1);
  endtask

  task automatic reset_engine_model();
    half_ticks = HALF_PERIOD_RESET;
    bus_state  = ST_IDLE;
    tick_cnt   = '0;
    bit_cnt    = '0;
    byte_cnt   = '0;
    shreg      = '0;
    cmd_addr   = '0;
    cmd_rnw    = 1'b0;
    cmd_count  = '0;
    nack_seen  = 1'b0;
    bus_scl    = 1'b1;
    bus_sda    = 1'b1;
    addr_phase = 1'b0;
  endtask

  // advance the model by one accepted transaction and queue its result
  task automatic engine_step(input i2cm_in_t req);
    i2cm_out_t  want;
    logic [7:0] hp;
    logic [7:0] rdata;
    logic       rvalid;
    logic       done;
    rdata  = '0;
    rvalid = 1'b0;
    done   = 1'b0;
    if (bus_state == ST_IDLE) begin
      if (req.mode == OP_START) begin
        cmd_addr   = req.address;
        cmd_rnw    = req.read_not_write;
        cmd_count  = req.byte_count;
        nack_seen  = 1'b0;
        byte_cnt   = '0;
        bit_cnt    = '0;
        shreg      = '0;
        tick_cnt   = '0;
        addr_phase = 1'b1;
        enter_state(ST_START_A, 1'b1, 1'b1);
      end
    end else if (req.mode == OP_TICK) begin
      hp = (half_ticks == 8'd0) ? 8'd1 : half_ticks;
      tick_cnt = tick_cnt + 8'd1;
      if (tick_cnt >= hp) begin
        tick_cnt = '0;
        unique case (bus_state)
          ST_START_A: enter_state(ST_START_B, 1'b1, 1'b0);
          ST_START_B: enter_state(ST_START_C, 1'b0, 1'b0);
          ST_START_C: load_tx_byte({cmd_addr, cmd_rnw});
          ST_TX_HIGH: enter_state(ST_TX_LOW, 1'b0, bus_sda);
          ST_TX_LOW: begin
            bit_cnt = bit_cnt + 4'd1;
            if (bit_cnt < 4'd8) begin
              shreg = shreg << 1;
              enter_state(ST_TX_HIGH, 1'b1, shreg[7]);
            end else begin
              enter_state(ST_ACK_HIGH, 1'b1, 1'b1);
            end
          end
          ST_ACK_HIGH: begin
            if (req.sda_in) nack_seen = 1'b1;
            else if (addr_phase) addr_phase = 1'b0;
            else byte_cnt = byte_cnt + 8'd1;
            enter_state(ST_ACK_LOW, 1'b0, 1'b1);
          end
          ST_ACK_LOW: begin
            if (nack_seen || byte_cnt >= cmd_count) enter_state(ST_STOP_A, 1'b0, 1'b0);
            else if (cmd_rnw) load_rx_byte();
            else load_tx_byte(req.write_data);
          end
          ST_RX_HIGH: begin
            shreg = {shreg[6:0], req.sda_in};
            enter_state(ST_RX_LOW, 1'b0, 1'b1);
          end
          ST_RX_LOW: begin
            bit_cnt = bit_cnt + 4'd1;
            if (bit_cnt < 4'd8) begin
              enter_state(ST_RX_HIGH, 1'b1, 1'b1);
            end else begin
              rvalid = 1'b1;
              rdata  = shreg;
              // nack the last byte
              enter_state(ST_MACK_HIGH, 1'b1, ({1'b0, byte_cnt} + 9'd1) >= {1'b0, cmd_count});
            end
          end
          ST_MACK_HIGH: enter_state(ST_MACK_LOW, 1'b0, 1'b1);
          ST_MACK_LOW: begin
            byte_cnt = byte_cnt + 8'd1;
            if (byte_cnt < cmd_count) load_rx_byte();
            else enter_state(ST_STOP_A, 1'b0, 1'b0);
          end
          ST_STOP_A: enter_state(ST_STOP_B, 1'b1, 1'b0);
          ST_STOP_B: enter_state(ST_STOP_C, 1'b1, 1'b1);
          default: begin
            done = 1'b1;
            enter_state(ST_IDLE, 1'b1, 1'b1);
          end
        endcase
      end
    end
    want.scl_out    = bus_scl;
    want.sda_out    = bus_sda;
    want.byte_index = byte_cnt;
    want.read_data  = rdata;
    want.read_valid = rvalid;
    want.busy_res   = (bus_state != ST_IDLE);
    want.done_res   = done;
    want.nack_error = nack_seen;
    expected_q.push_back(want);
  endtask

  function automatic i2cm_in_t tick_item();
    i2cm_in_t it;
    int       ack_no;
    it.mode           = OP_TICK;
    it.address        = 7'($urandom);
    it.read_not_write = 1'($urandom);
    it.byte_count     = 8'($urandom);
    it.write_data     = 8'($urandom);
    it.sda_in         = 1'($urandom);
    if (bus_state == ST_ACK_HIGH) begin
      ack_no = addr_phase ? 0 : int'(byte_cnt) + 1;
      if (nack_plan == NACK_RANDOM) it.sda_in = ($urandom_range(0, 99) < 5);
      else it.sda_in = (nack_plan == ack_no);
    end
    return it;
  endfunction

  function automatic i2cm_in_t start_item(input logic [6:0] addr, input logic rnw,
                                          input logic [7:0] count);
    i2cm_in_t it;
    it.mode           = OP_START;
    it.address        = addr;
    it.read_not_write = rnw;
    it.byte_count     = count;
    it.write_data     = 8'($urandom);
    it.sda_in         = 1'($urandom);
    return it;
  endfunction

  task automatic send_item(input i2cm_in_t it);
    while (!steady_flow && $urandom_range(0, 99) < 20) begin
      @(negedge clk);
      push <= 1'b0;
    end
    @(negedge clk);
    push    <= 1'b1;
    request <= it;
    do @(posedge clk); while (full);
    engine_step(it);
    items_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    push <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_half_period(input logic [7:0] value);
    wait_drained();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    half_ticks = value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic begin_transfer(input logic [6:0] addr, input logic rnw, input logic [7:0] count);
    send_item(start_item(addr, rnw, count));
  endtask

  // tick until STOP completes, with stray starts mixed in
  task automatic finish_transfer(input int stray_pct);
    while (bus_state != ST_IDLE) begin
      if ($urandom_range(0, 99) < stray_pct)
        send_item(start_item(7'($urandom), 1'($urandom), 8'($urandom)));
      send_item(tick_item());
    end
  endtask

  task automatic test_reset_rate();
    nack_plan = NACK_NEVER;
    repeat (4) send_item(tick_item());
    begin_transfer(7'h7F, 1'b0, 8'd0);
    repeat (11) send_item(tick_item());
    write_half_period(8'd1);
    finish_transfer(0);
  endtask

  task automatic test_zero_half_period();
    write_half_period(8'd0);
    nack_plan = NACK_NEVER;
    begin_transfer(7'h55, 1'b0, 8'd1);
    finish_transfer(0);
  endtask

  task automatic test_reads();
    write_half_period(8'd1);
    nack_plan = NACK_NEVER;
    begin_transfer(7'h00, 1'b1, 8'd2);
    finish_transfer(0);
  endtask

  task automatic test_nack_endings();
    nack_plan = 0;
    begin_transfer(7'h2A, 1'b0, 8'hFF);
    finish_transfer(0);
    nack_plan = 1;
    begin_transfer(7'h33, 1'b0, 8'd2);
    finish_transfer(0);
  endtask

  task automatic test_start_while_busy();
    nack_plan = NACK_NEVER;
    begin_transfer(7'h41, 1'b0, 8'd0);
    finish_transfer(25);
  endtask

  task automatic test_rate_change_mid_transfer();
    nack_plan = NACK_NEVER;
    write_half_period(8'd255);
    begin_transfer(7'h5A, 1'b0, 8'd0);
    repeat (20) send_item(tick_item());
    // counter already past the new length
    write_half_period(8'd1);
    finish_transfer(0);
  endtask

  task automatic test_backpressure();
    write_half_period(8'd1);
    nack_plan = NACK_NEVER;
    begin_transfer(7'h3C, 1'b0, 8'd1);
    hold_requests++;
    repeat (30) send_item(tick_item());
    finish_transfer(0);
    wait_drained();
  endtask

  task automatic random_transfer();
    int unsigned r;
    logic [7:0]  count;
    r = $urandom_range(0, 99);
    if (r < 25) count = 8'd0;
    else if (r < 85) count = 8'($urandom_range(1, 2));
    else count = 8'($urandom_range(3, 4));
    nack_plan = NACK_RANDOM;
    begin_transfer(7'($urandom), 1'($urandom), count);
    finish_transfer(3);
    repeat ($urandom_range(0, 2)) send_item(tick_item());
  endtask

  task automatic test_random_transfers();
    int rates[3];
    int stop_at;
    rates = '{1, 0, 2};
    foreach (rates[p]) begin
      write_half_period(8'(rates[p]));
      steady_flow = (p == 1);
      stop_at = items_sent + RANDOM_ITEMS / 3;
      while (items_sent < stop_at) random_transfer();
      steady_flow = 1'b0;
    end
  endtask

  // result side
  initial begin
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    pop = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_seen != hold_requests) begin
        hold_seen = hold_requests;
        hold_left = RX_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= steady_flow || ($urandom_range(0, 99) >= 20);
      end
    end
  end

  function automatic bit same_result(input i2cm_out_t a, input i2cm_out_t b);
    return a.scl_out === b.scl_out && a.sda_out === b.sda_out &&
           a.byte_index === b.byte_index && a.read_data === b.read_data &&
           a.read_valid === b.read_valid && a.busy_res === b.busy_res &&
           a.done_res === b.done_res && a.nack_error === b.nack_error;
  endfunction

  task automatic note_error(input string what, input i2cm_out_t want, input i2cm_out_t got);
    errors++;
    if (errors <= MAX_REPORTS) begin
      $display("%0t %s: expected scl %b sda %b idx %0d rd %h rv %b busy %b done %b nack %b",
               $realtime, what, want.scl_out, want.sda_out, want.byte_index, want.read_data,
               want.read_valid, want.busy_res, want.done_res, want.nack_error);
      $display("%0t %s: actual   scl %b sda %b idx %0d rd %h rv %b busy %b done %b nack %b",
               $realtime, what, got.scl_out, got.sda_out, got.byte_index, got.read_data,
               got.read_valid, got.busy_res, got.done_res, got.nack_error);
    end
  endtask

  always @(posedge clk) begin : check_results
    i2cm_out_t want;
    if (!rst && pop && !empty) begin
      if (expected_q.size() == 0) begin
        note_error("unexpected result", '0, result);
      end else begin
        want = expected_q.pop_front();
        if (!same_result(want, result)) note_error("result mismatch", want, result);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_i2c_master_bit_engine: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst         = 1'b1;
    push        = 1'b0;
    request     = '0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    reset_engine_model();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_rate();
    test_zero_half_period();
    test_reads();
    test_nack_endings();
    test_start_while_busy();
    test_rate_change_mid_transfer();
    test_backpressure();
    test_random_transfers();

    wait_drained();
    repeat (8) @(posedge clk);
    if (errors == 0) $display("tb_i2c_master_bit_engine: clean");
    else $display("tb_i2c_master_bit_engine: errors");
    $finish;
  end

endmodule
`default_nettype wire
